>>> hw/rtl/pirfh_pkg.sv
`default_nettype none
package pirfh_pkg;

  // table and field sizes
  localparam int MaxRects = 256;
  localparam int IdxW     = 8;
  localparam int CoordW   = 24;
  localparam int SizeW    = CoordW - 1;
  localparam int TagW     = 16;
  localparam int CntW     = 9;
  localparam int HitW     = 16;

  // queue depths
  localparam int CmdDepth = 4;
  localparam int CmdPtrW  = 2;
  localparam int ResDepth = 2;
  localparam int ResPtrW  = 1;

  // request opcodes
  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  // one accepted request
  typedef struct packed {
    logic                     opcode;
    logic [IdxW-1:0]          entry_index;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic [SizeW-1:0]         rect_width;
    logic [SizeW-1:0]         rect_height;
    logic [TagW-1:0]          point_tag;
    logic                     last_point;
  } cmd_t;

  // one result
  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] rect_index;
    logic [TagW-1:0] tag_out;
    logic [HitW-1:0] hit_total;
    logic            batch_end;
  } res_t;

  // stored rectangle, right and bottom edges precomputed one bit wider
  typedef struct packed {
    logic signed [CoordW-1:0] left;
    logic signed [CoordW-1:0] top;
    logic signed [CoordW:0]   right;
    logic signed [CoordW:0]   bottom;
  } rect_t;

endpackage
`default_nettype wire

>>> hw/rtl/pirfh_cmd_q.sv
`default_nettype none
module pirfh_cmd_q (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               full_o,
  input  wire pirfh_pkg::cmd_t cmd_i,
  output logic               head_vld_o,
  output pirfh_pkg::cmd_t    head_o,
  input  wire logic          pop_i
);
  import pirfh_pkg::*;

  cmd_t               mem_q [CmdDepth];
  logic [CmdPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CmdPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CmdPtrW:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  // flags
  assign full_o     = (cnt_q == (CmdPtrW+1)'(CmdDepth));
  assign head_vld_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && head_vld_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + CmdPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + CmdPtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (CmdPtrW+1)'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - (CmdPtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/pirfh_res_q.sv
`default_nettype none
module pirfh_res_q (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  output logic                 full_o,
  input  wire pirfh_pkg::res_t res_i,
  output logic                 empty_o,
  output pirfh_pkg::res_t      res_o,
  input  wire logic            pop_i
);
  import pirfh_pkg::*;

  res_t               mem_q [ResDepth];
  logic [ResPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [ResPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [ResPtrW:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  // flags
  assign full_o  = (cnt_q == (ResPtrW+1)'(ResDepth));
  assign empty_o = (cnt_q == '0);
  assign res_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + ResPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + ResPtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (ResPtrW+1)'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - (ResPtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/pirfh_scan.sv
`default_nettype none
module pirfh_scan (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [pirfh_pkg::CntW-1:0]    active_i,
  input  wire logic                          cmd_vld_i,
  input  wire pirfh_pkg::cmd_t               cmd_i,
  output logic                               cmd_pop_o,
  output logic                               res_push_o,
  output pirfh_pkg::res_t                    res_o,
  input  wire logic                          res_full_i
);
  import pirfh_pkg::*;

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StScan   = 3'b010,
    StResult = 3'b100
  } state_e;

  state_e state_q, state_d;

  // rectangle table, one write and one registered read port
  rect_t mem_q [MaxRects];
  rect_t rd_rect_q;
  rect_t wr_rect;
  logic  mem_we, rd_en;

  // scan control
  logic [IdxW-1:0]          addr_q, addr_d;
  logic [IdxW-1:0]          last_idx_q, last_idx_d;
  logic [IdxW-1:0]          rd_idx_q, rd_idx_d;
  logic                     issue_q, issue_d;
  logic                     rd_vld_q, rd_vld_d;
  logic [HitW-1:0]          hits_q, hits_d;

  // query payload
  logic signed [CoordW-1:0] px_q, px_d;
  logic signed [CoordW-1:0] py_q, py_d;
  logic [TagW-1:0]          tag_q, tag_d;
  logic                     last_q, last_d;
  res_t                     res_q, res_d;

  // finish signals
  logic                     finish, fin_hit;
  logic [IdxW-1:0]          fin_idx;
  logic [HitW-1:0]          hits_next;
  logic                     inside_hit;
  logic signed [CoordW:0]   px_ext, py_ext;

  // edges of the written rectangle
  always_comb begin
    wr_rect.left   = cmd_i.coord_x;
    wr_rect.top    = cmd_i.coord_y;
    wr_rect.right  = $signed({cmd_i.coord_x[CoordW-1], cmd_i.coord_x})
                   + $signed({2'b00, cmd_i.rect_width});
    wr_rect.bottom = $signed({cmd_i.coord_y[CoordW-1], cmd_i.coord_y})
                   + $signed({2'b00, cmd_i.rect_height});
  end

  // strict containment test on the entry read last cycle
  assign px_ext = {px_q[CoordW-1], px_q};
  assign py_ext = {py_q[CoordW-1], py_q};
  assign inside_hit = (px_q > rd_rect_q.left) && (px_ext < rd_rect_q.right)
                   && (py_q > rd_rect_q.top)  && (py_ext < rd_rect_q.bottom);

  // saturating batch count
  assign hits_next = (fin_hit && (hits_q != {HitW{1'b1}})) ? hits_q + HitW'(1) : hits_q;

  // control sequencer
  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    last_idx_d = last_idx_q;
    rd_idx_d   = rd_idx_q;
    issue_d    = issue_q;
    rd_vld_d   = rd_vld_q;
    px_d       = px_q;
    py_d       = py_q;
    tag_d      = tag_q;
    last_d     = last_q;
    res_d      = res_q;
    hits_d     = hits_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    finish     = 1'b0;
    fin_hit    = 1'b0;
    fin_idx    = '0;
    unique case (state_q)
      StIdle: begin
        if (cmd_vld_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.opcode == OpWrite) begin
            mem_we = 1'b1;
          end else begin
            px_d   = cmd_i.coord_x;
            py_d   = cmd_i.coord_y;
            tag_d  = cmd_i.point_tag;
            last_d = cmd_i.last_point;
            if (active_i == '0) begin
              // empty scan: plain miss
              finish  = 1'b1;
              state_d = StResult;
            end else begin
              addr_d   = '0;
              issue_d  = 1'b1;
              rd_vld_d = 1'b0;
              state_d  = StScan;
              if (active_i >= CntW'(MaxRects)) begin
                last_idx_d = IdxW'(MaxRects - 1);
              end else begin
                last_idx_d = active_i[IdxW-1:0] - IdxW'(1);
              end
            end
          end
        end
      end
      StScan: begin
        // issue one read per cycle
        rd_en    = issue_q;
        rd_vld_d = issue_q;
        rd_idx_d = addr_q;
        if (issue_q) begin
          if (addr_q == last_idx_q) begin
            issue_d = 1'b0;
          end else begin
            addr_d = addr_q + IdxW'(1);
          end
        end
        // check the entry that came back
        if (rd_vld_q && (inside_hit || (rd_idx_q == last_idx_q))) begin
          finish   = 1'b1;
          fin_hit  = inside_hit;
          fin_idx  = inside_hit ? rd_idx_q : '0;
          issue_d  = 1'b0;
          rd_vld_d = 1'b0;
          state_d  = StResult;
        end
      end
      StResult: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    if (finish) begin
      res_d.hit        = fin_hit;
      res_d.rect_index = fin_idx;
      res_d.tag_out    = (state_q == StIdle) ? cmd_i.point_tag : tag_q;
      res_d.hit_total  = hits_next;
      res_d.batch_end  = (state_q == StIdle) ? cmd_i.last_point : last_q;
      hits_d           = res_d.batch_end ? '0 : hits_next;
    end
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      issue_q  <= 1'b0;
      rd_vld_q <= 1'b0;
      hits_q   <= '0;
    end else begin
      state_q  <= state_d;
      issue_q  <= issue_d;
      rd_vld_q <= rd_vld_d;
      hits_q   <= hits_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    last_idx_q <= last_idx_d;
    rd_idx_q   <= rd_idx_d;
    px_q       <= px_d;
    py_q       <= py_d;
    tag_q      <= tag_d;
    last_q     <= last_d;
    res_q      <= res_d;
  end

  // table write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[cmd_i.entry_index] <= wr_rect;
    end
    if (rd_en) begin
      rd_rect_q <= mem_q[addr_q];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/point_in_rect_first_hit.sv
// a query scans up to min(active_rects, 256) table entries and stops at the first hit, and a
// query with active_rects at zero is a plain miss without a scan. the scan reads one
// table entry per cycle from the table's single read port, and the back end takes the
// next request only after the current query's result has been pushed
// requests queue up to 4 deep in front of the scan, results up to 2 deep behind it
// reset clears the queues, the batch hit count and active_rects; table stays undefined
`default_nettype none
module point_in_rect_first_hit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [pirfh_pkg::CntW-1:0]        cfg_wdata_i,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic                              opcode_i,
  input  wire logic [pirfh_pkg::IdxW-1:0]        entry_index_i,
  input  wire logic signed [pirfh_pkg::CoordW-1:0] coord_x_i,
  input  wire logic signed [pirfh_pkg::CoordW-1:0] coord_y_i,
  input  wire logic [pirfh_pkg::SizeW-1:0]       rect_width_i,
  input  wire logic [pirfh_pkg::SizeW-1:0]       rect_height_i,
  input  wire logic [pirfh_pkg::TagW-1:0]        point_tag_i,
  input  wire logic                              last_point_i,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic                                   hit_o,
  output logic [pirfh_pkg::IdxW-1:0]             rect_index_o,
  output logic [pirfh_pkg::TagW-1:0]             tag_out_o,
  output logic [pirfh_pkg::HitW-1:0]             hit_total_o,
  output logic                                   batch_end_o
);
  import pirfh_pkg::*;

  logic [CntW-1:0] active_q;
  cmd_t            cmd_in, head;
  logic            head_vld, head_pop;
  res_t            scan_res, out_res;
  logic            res_push, res_full;

  // active rectangle count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  // pack incoming request
  always_comb begin
    cmd_in.opcode      = opcode_i;
    cmd_in.entry_index = entry_index_i;
    cmd_in.coord_x     = coord_x_i;
    cmd_in.coord_y     = coord_y_i;
    cmd_in.rect_width  = rect_width_i;
    cmd_in.rect_height = rect_height_i;
    cmd_in.point_tag   = point_tag_i;
    cmd_in.last_point  = last_point_i;
  end

  // front request queue
  pirfh_cmd_q u_cmd_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .cmd_i      (cmd_in),
    .head_vld_o (head_vld),
    .head_o     (head),
    .pop_i      (head_pop)
  );

  // table and scan engine
  pirfh_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .active_i   (active_q),
    .cmd_vld_i  (head_vld),
    .cmd_i      (head),
    .cmd_pop_o  (head_pop),
    .res_push_o (res_push),
    .res_o      (scan_res),
    .res_full_i (res_full)
  );

  // result queue
  pirfh_res_q u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .res_i   (scan_res),
    .empty_o (empty),
    .res_o   (out_res),
    .pop_i   (pop)
  );

  // unpack result
  assign hit_o        = out_res.hit;
  assign rect_index_o = out_res.rect_index;
  assign tag_out_o    = out_res.tag_out;
  assign hit_total_o  = out_res.hit_total;
  assign batch_end_o  = out_res.batch_end;

endmodule
`default_nettype wire
